>>> hdl/pidq_pkg.sv
// ----------------------------------------------------------------------------
// pidq_pkg
// Shared types, constants and the microcode program of the PID controller
// with quadrature encoder feedback.
// ----------------------------------------------------------------------------
`default_nettype none

package pidq_pkg;

  // Field and register widths.
  localparam int KW       = 32;
  localparam int AlphaW   = 17;
  localparam int PerW     = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int SpRawW   = 12;
  localparam int PosW     = 32;
  localparam int DriveW   = 16;
  localparam int ErrW     = 48;
  localparam int SumW     = 64;
  localparam int ProdW    = 66;
  localparam int AccW     = 100;
  localparam int DivW     = 60;
  localparam int DsrW     = 10;
  localparam int DivSteps = DivW / 2;
  localparam int DivCntW  = 5;
  localparam int PcW      = 6;
  localparam int UcodeLen = 37;

  // Register reset values.
  localparam logic [KW-1:0]     KpReset     = 32'd196608;
  localparam logic [KW-1:0]     KiReset     = 32'd66;
  localparam logic [KW-1:0]     KdReset     = 32'd655;
  localparam logic [AlphaW-1:0] AlphaReset  = 17'd65536;
  localparam logic [PerW-1:0]   PeriodReset = 10'd5;

  // Arithmetic constants.
  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;
  localparam logic [DsrW-1:0]   DivK     = 10'd1000;
  localparam logic signed [ErrW-1:0] ErrMax = {1'b0, {(ErrW-1){1'b1}}};
  localparam logic signed [ErrW-1:0] ErrMin = {1'b1, {(ErrW-1){1'b0}}};
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_PERIOD = 3'd4
  } cfg_idx_e;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  // Divider states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_e;

  // Micro-operations of the datapath.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LDX,
    UOP_MUL,
    UOP_SS,
    UOP_ERR,
    UOP_DIV,
    UOP_ESUM,
    UOP_DERIV,
    UOP_SLOPE,
    UOP_ABS,
    UOP_DRIVE
  } uop_e;

  // Sources of the multiplier operand register.
  typedef enum logic [2:0] {
    XS_FSP,
    XS_ERR,
    XS_DERR,
    XS_DSL,
    XS_ESUM,
    XS_SLOPE
  } xsrc_e;

  // Sources of the coefficient operand (and of the divisor).
  typedef enum logic [2:0] {
    BS_ALPHA,
    BS_PER,
    BS_K1000,
    BS_KP,
    BS_KI,
    BS_KD
  } bsrc_e;

  // Jump conditions.
  typedef enum logic {
    JC_NONE,
    JC_DIV_BUSY
  } jcond_e;

  // One control word of the program.
  typedef struct packed {
    uop_e             op;
    xsrc_e            xsrc;
    bsrc_e            bsrc;
    logic             hi;
    logic             clr;
    jcond_e           jc;
    logic [PcW-1:0]   jmp;
  } uword_t;

  // Addresses of the two divider wait loops.
  localparam logic [PcW-1:0] PcWaitInc = 6'd11;
  localparam logic [PcW-1:0] PcWaitDrv = 6'd18;

  // Saturate a wide signed value to the signed 48-bit range.
  function automatic logic signed [ErrW-1:0] sat_err(input logic signed [DivW-1:0] v);
    logic signed [ErrW-1:0] r;
    if ((v[DivW-1:ErrW-1] == '0) || (v[DivW-1:ErrW-1] == '1)) begin
      r = v[ErrW-1:0];
    end else if (v[DivW-1]) begin
      r = ErrMin;
    end else begin
      r = ErrMax;
    end
    return r;
  endfunction

  // Build a control word.
  function automatic uword_t mk(input uop_e op, input xsrc_e xs, input bsrc_e bs,
                                input logic hi, input logic clr, input jcond_e jc,
                                input logic [PcW-1:0] jmp);
    uword_t w;
    w.op   = op;
    w.xsrc = xs;
    w.bsrc = bs;
    w.hi   = hi;
    w.clr  = clr;
    w.jc   = jc;
    w.jmp  = jmp;
    return w;
  endfunction

  // The control-step program. A multiply issues a low and a high half;
  // each product is added to the accumulator in the cycle after it.
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // Reference filter: ss += floor(alpha * (target - ss) / 2^16).
      6'd0:  w = mk(UOP_LDX,   XS_FSP,   BS_ALPHA, 1'b0, 1'b1, JC_NONE, '0);
      6'd1:  w = mk(UOP_MUL,   XS_FSP,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      6'd2:  w = mk(UOP_MUL,   XS_FSP,   BS_ALPHA, 1'b1, 1'b0, JC_NONE, '0);
      6'd3:  w = mk(UOP_NOP,   XS_FSP,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      6'd4:  w = mk(UOP_SS,    XS_FSP,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      6'd5:  w = mk(UOP_ERR,   XS_FSP,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      // Integral increment: error * period / 1000.
      6'd6:  w = mk(UOP_LDX,   XS_ERR,   BS_PER,   1'b0, 1'b1, JC_NONE, '0);
      6'd7:  w = mk(UOP_MUL,   XS_ERR,   BS_PER,   1'b0, 1'b0, JC_NONE, '0);
      6'd8:  w = mk(UOP_MUL,   XS_ERR,   BS_PER,   1'b1, 1'b0, JC_NONE, '0);
      6'd9:  w = mk(UOP_NOP,   XS_ERR,   BS_PER,   1'b0, 1'b0, JC_NONE, '0);
      6'd10: w = mk(UOP_DIV,   XS_ERR,   BS_K1000, 1'b0, 1'b0, JC_NONE, '0);
      6'd11: w = mk(UOP_NOP,   XS_ERR,   BS_K1000, 1'b0, 1'b0, JC_DIV_BUSY, PcWaitInc);
      6'd12: w = mk(UOP_ESUM,  XS_ERR,   BS_K1000, 1'b0, 1'b0, JC_NONE, '0);
      // Derivative: (error - prior error) * 1000 / period.
      6'd13: w = mk(UOP_LDX,   XS_DERR,  BS_K1000, 1'b0, 1'b1, JC_NONE, '0);
      6'd14: w = mk(UOP_MUL,   XS_DERR,  BS_K1000, 1'b0, 1'b0, JC_NONE, '0);
      6'd15: w = mk(UOP_MUL,   XS_DERR,  BS_K1000, 1'b1, 1'b0, JC_NONE, '0);
      6'd16: w = mk(UOP_NOP,   XS_DERR,  BS_K1000, 1'b0, 1'b0, JC_NONE, '0);
      6'd17: w = mk(UOP_DIV,   XS_DERR,  BS_PER,   1'b0, 1'b0, JC_NONE, '0);
      6'd18: w = mk(UOP_NOP,   XS_DERR,  BS_PER,   1'b0, 1'b0, JC_DIV_BUSY, PcWaitDrv);
      6'd19: w = mk(UOP_DERIV, XS_DERR,  BS_PER,   1'b0, 1'b0, JC_NONE, '0);
      // Derivative filter.
      6'd20: w = mk(UOP_LDX,   XS_DSL,   BS_ALPHA, 1'b0, 1'b1, JC_NONE, '0);
      6'd21: w = mk(UOP_MUL,   XS_DSL,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      6'd22: w = mk(UOP_MUL,   XS_DSL,   BS_ALPHA, 1'b1, 1'b0, JC_NONE, '0);
      6'd23: w = mk(UOP_NOP,   XS_DSL,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      6'd24: w = mk(UOP_SLOPE, XS_DSL,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
      // Output sum kp*e + ki*sum + kd*slope.
      6'd25: w = mk(UOP_LDX,   XS_ERR,   BS_KP,    1'b0, 1'b1, JC_NONE, '0);
      6'd26: w = mk(UOP_MUL,   XS_ERR,   BS_KP,    1'b0, 1'b0, JC_NONE, '0);
      6'd27: w = mk(UOP_MUL,   XS_ERR,   BS_KP,    1'b1, 1'b0, JC_NONE, '0);
      6'd28: w = mk(UOP_LDX,   XS_ESUM,  BS_KI,    1'b0, 1'b0, JC_NONE, '0);
      6'd29: w = mk(UOP_MUL,   XS_ESUM,  BS_KI,    1'b0, 1'b0, JC_NONE, '0);
      6'd30: w = mk(UOP_MUL,   XS_ESUM,  BS_KI,    1'b1, 1'b0, JC_NONE, '0);
      6'd31: w = mk(UOP_LDX,   XS_SLOPE, BS_KD,    1'b0, 1'b0, JC_NONE, '0);
      6'd32: w = mk(UOP_MUL,   XS_SLOPE, BS_KD,    1'b0, 1'b0, JC_NONE, '0);
      6'd33: w = mk(UOP_MUL,   XS_SLOPE, BS_KD,    1'b1, 1'b0, JC_NONE, '0);
      6'd34: w = mk(UOP_NOP,   XS_SLOPE, BS_KD,    1'b0, 1'b0, JC_NONE, '0);
      6'd35: w = mk(UOP_ABS,   XS_SLOPE, BS_KD,    1'b0, 1'b0, JC_NONE, '0);
      6'd36: w = mk(UOP_DRIVE, XS_SLOPE, BS_KD,    1'b0, 1'b0, JC_NONE, '0);
      default: w = mk(UOP_NOP, XS_FSP,   BS_ALPHA, 1'b0, 1'b0, JC_NONE, '0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pidq_div.sv
// ----------------------------------------------------------------------------
// pidq_div
// Signed divider by a small unsigned divisor, quotient truncated toward zero.
// Works on the magnitude, two quotient bits per cycle, then applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module pidq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pidq_pkg::DivW-1:0]    dividend_i,
  input  logic [pidq_pkg::DsrW-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [pidq_pkg::DivW-1:0]    quot_o
);
  import pidq_pkg::*;

  div_state_e           state_q, state_d;
  logic [DivCntW-1:0]   cnt_q;
  logic [DivW-1:0]      work_q;
  logic [DsrW-1:0]      rem_q;
  logic [DsrW-1:0]      dsr_q;
  logic                 neg_q;
  logic [DivW-1:0]      work_d;
  logic [DsrW-1:0]      rem_d;
  logic [DsrW:0]        trial;

  // Two restoring division steps per cycle.
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      trial  = {rem_d, work_d[DivW-1]};
      work_d = {work_d[DivW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d     = DsrW'(trial - {1'b0, dsr_q});
        work_d[0] = 1'b1;
      end else begin
        rem_d = trial[DsrW-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = DIV_FIX;
      end
      DIV_FIX: begin
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      neg_q  <= dividend_i[DivW-1];
      work_q <= dividend_i[DivW-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (state_q == DIV_RUN) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end else if (state_q == DIV_FIX) begin
      work_q <= neg_q ? (~work_q + 1'b1) : work_q;
    end
  end

  assign busy_o = (state_q != DIV_IDLE);
  assign quot_o = work_q;

endmodule

`default_nettype wire

>>> hdl/pid_with_quadrature_feedback.sv
// ----------------------------------------------------------------------------
// pid_with_quadrature_feedback
// PID position controller with a quadrature encoder count, filtered reference
// and filtered derivative, run by a microcoded sequencer over one datapath.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o action, enc_a, enc_b, setpoint_raw
//   out      out        out_valid_o/out_stall_i drive, drive_clipped, position
//
// An encoder sample passes from acceptance through the emit state, which loads
// the output register once the output is free. A control step runs 37 microcode
// steps plus two passes of the shared divider (two quotient bits a cycle). One
// item is worked at a time; the next is accepted while a result waits. Reset is
// asynchronous and active low; it restores the sequencer, configuration and most
// controller-state registers to defaults; work and output data are not reset.
`default_nettype none

module pid_with_quadrature_feedback #(
  parameter int SETPOINT_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pidq_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pidq_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic                                 enc_a_i,
  input  logic                                 enc_b_i,
  input  logic [pidq_pkg::SpRawW-1:0]          setpoint_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pidq_pkg::DriveW-1:0]   drive_o,
  output logic                                 drive_clipped_o,
  output logic signed [pidq_pkg::PosW-1:0]     position_o
);
  import pidq_pkg::*;

  localparam int SpUsed = (SETPOINT_BITS < SpRawW) ? SETPOINT_BITS : SpRawW;

  // Control.
  state_e               state_q, state_d;
  logic [PcW-1:0]       pc_q, pc_d;
  uword_t               uw;
  logic                 run;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_valid_q;

  // Configuration.
  logic [KW-1:0]        kp_q, ki_q, kd_q;
  logic [AlphaW-1:0]    alpha_q;
  logic [PerW-1:0]      period_q;

  // Controller state.
  logic [PosW-1:0]             pos_q;
  logic                        pha_q;
  logic [SpUsed-1:0]           sp_q;
  logic [PosW-1:0]             ss_q;
  logic signed [ErrW-1:0]      err_q, perr_q, dv_q, slope_q;
  logic signed [SumW-1:0]      esum_q;
  logic signed [DriveW-1:0]    drv_q;
  logic                        clip_q;

  // Datapath work registers.
  logic signed [SumW-1:0]      x_q;
  logic signed [ProdW-1:0]     p_q;
  logic                        pvld_q, phi_q;
  logic signed [AccW-1:0]      acc_q, acc_d;
  logic                        neg_q;

  // Output register.
  logic signed [DriveW-1:0]    out_drive_q;
  logic                        out_clip_q;
  logic [PosW-1:0]             out_pos_q;

  // Combinational datapath values.
  logic [AlphaW-1:0]           a_eff;
  logic [PerW-1:0]             per_eff;
  logic [PosW-1:0]             target;
  logic signed [PosW:0]        fsp_diff;
  logic signed [ErrW:0]        derr, dsl;
  logic signed [SumW-1:0]      x_mux;
  logic [KW-1:0]               b_mux;
  logic signed [KW:0]          mul_a, mul_b;
  logic signed [ProdW-1:0]     prod;
  logic signed [AccW-1:0]      padd;
  logic signed [ErrW+1:0]      err_raw;
  logic signed [SumW:0]        esum_sum;
  logic signed [SumW-1:0]      esum_sat;
  logic signed [ErrW+1:0]      slope_sum;
  logic [AccW-33:0]            mag_hi;
  logic [AccW-33:0]            dmax;
  logic                        drv_clip;
  logic signed [DriveW-1:0]    drv_val;
  logic                        div_start, div_busy;
  logic [DsrW-1:0]             div_dsr;
  logic [DivW-1:0]             div_quot;

  // Handshake and program fetch.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign uw          = ucode_rom(pc_q);
  assign run         = (state_q == ST_RUN);

  // Effective coefficients.
  assign a_eff   = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign per_eff = (period_q == '0) ? PerW'(1) : period_q;
  assign target  = PosW'(sp_q) << 16;

  // Operand sources.
  assign fsp_diff = $signed({1'b0, target}) - $signed({1'b0, ss_q});
  assign derr     = (ErrW+1)'(err_q) - (ErrW+1)'(perr_q);
  assign dsl      = (ErrW+1)'(dv_q) - (ErrW+1)'(slope_q);

  always_comb begin
    case (uw.xsrc)
      XS_FSP:   x_mux = SumW'(fsp_diff);
      XS_ERR:   x_mux = SumW'(err_q);
      XS_DERR:  x_mux = SumW'(derr);
      XS_DSL:   x_mux = SumW'(dsl);
      XS_ESUM:  x_mux = esum_q;
      XS_SLOPE: x_mux = SumW'(slope_q);
      default:  x_mux = '0;
    endcase
  end

  always_comb begin
    case (uw.bsrc)
      BS_ALPHA: b_mux = KW'(a_eff);
      BS_PER:   b_mux = KW'(per_eff);
      BS_K1000: b_mux = KW'(DivK);
      BS_KP:    b_mux = kp_q;
      BS_KI:    b_mux = ki_q;
      BS_KD:    b_mux = kd_q;
      default:  b_mux = '0;
    endcase
  end

  // Shared 33x33 multiplier over one half of the operand register.
  assign mul_a = uw.hi ? (KW+1)'($signed(x_q[SumW-1:KW])) : $signed({1'b0, x_q[KW-1:0]});
  assign mul_b = $signed({1'b0, b_mux});
  assign prod  = mul_a * mul_b;

  // Accumulator: clear, add the last product, or take the magnitude.
  assign padd = phi_q ? (AccW'(p_q) <<< KW) : AccW'(p_q);

  always_comb begin
    if (run && uw.op == UOP_ABS) begin
      acc_d = acc_q[AccW-1] ? -acc_q : acc_q;
    end else begin
      acc_d = ((run && uw.op == UOP_LDX && uw.clr) ? '0 : acc_q)
            + (pvld_q ? padd : '0);
    end
  end

  // Error against the position count, and the saturating updates.
  assign err_raw   = $signed({18'b0, ss_q}) - (ErrW+2)'($signed({pos_q, 16'b0}));
  assign esum_sum  = (SumW+1)'(esum_q) + (SumW+1)'($signed(div_quot));
  assign slope_sum = (ErrW+2)'(slope_q) + $signed(acc_q[ProdW-1:16]);

  always_comb begin
    if (esum_sum[SumW] != esum_sum[SumW-1]) begin
      esum_sat = esum_sum[SumW] ? SumMin : SumMax;
    end else begin
      esum_sat = esum_sum[SumW-1:0];
    end
  end

  // Drive: truncate the magnitude to an integer and saturate.
  assign mag_hi   = acc_q[AccW-1:32];
  assign dmax     = neg_q ? (AccW-32)'(32768) : (AccW-32)'(32767);
  assign drv_clip = (mag_hi > dmax);

  always_comb begin
    if (drv_clip) begin
      drv_val = neg_q ? $signed(16'h8000) : $signed(16'h7FFF);
    end else begin
      drv_val = neg_q ? -$signed(mag_hi[DriveW-1:0]) : $signed(mag_hi[DriveW-1:0]);
    end
  end

  // Shared divider.
  assign div_start = run && (uw.op == UOP_DIV);
  assign div_dsr   = (uw.bsrc == BS_PER) ? per_eff : DivK;

  pidq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q[DivW-1:0]),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Sequencer next state and step counter.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        pc_d = '0;
        if (in_acc) state_d = action_i ? ST_RUN : ST_EMIT;
      end
      ST_RUN: begin
        if (uw.op == UOP_DRIVE) begin
          state_d = ST_EMIT;
        end
        if (uw.jc == JC_DIV_BUSY && div_busy) begin
          pc_d = uw.jmp;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      pvld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pvld_q  <= run && (uw.op == UOP_MUL);
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KpReset;
      ki_q     <= KiReset;
      kd_q     <= KdReset;
      alpha_q  <= AlphaReset;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KP:     kp_q     <= cfg_data_i;
        CFG_KI:     ki_q     <= cfg_data_i;
        CFG_KD:     kd_q     <= cfg_data_i;
        CFG_ALPHA:  alpha_q  <= cfg_data_i[AlphaW-1:0];
        CFG_PERIOD: period_q <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  // Encoder count and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pha_q   <= 1'b0;
      ss_q    <= '0;
      perr_q  <= '0;
      esum_q  <= '0;
      slope_q <= '0;
      drv_q   <= '0;
      clip_q  <= 1'b0;
    end else begin
      if (in_acc && !action_i) begin
        if (enc_a_i != pha_q) begin
          pos_q <= (enc_a_i == enc_b_i) ? pos_q + 1'b1 : pos_q - 1'b1;
        end
        pha_q <= enc_a_i;
      end
      if (run) begin
        case (uw.op)
          UOP_SS:    ss_q    <= ss_q + acc_q[47:16];
          UOP_ESUM:  esum_q  <= esum_sat;
          UOP_DERIV: perr_q  <= err_q;
          UOP_SLOPE: slope_q <= sat_err(DivW'(slope_sum));
          UOP_DRIVE: begin
            drv_q  <= drv_val;
            clip_q <= drv_clip;
          end
          default: ;
        endcase
      end
    end
  end

  // Work registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i) begin
      sp_q <= setpoint_raw_i[SpUsed-1:0];
    end
    acc_q <= acc_d;
    if (run) begin
      case (uw.op)
        UOP_LDX:   x_q   <= x_mux;
        UOP_ERR:   err_q <= sat_err(DivW'(err_raw));
        UOP_DERIV: dv_q  <= sat_err($signed(div_quot));
        UOP_ABS:   neg_q <= acc_q[AccW-1];
        UOP_MUL: begin
          p_q   <= prod;
          phi_q <= uw.hi;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_drive_q <= drv_q;
      out_clip_q  <= clip_q;
      out_pos_q   <= pos_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = out_drive_q;
  assign drive_clipped_o = out_clip_q;
  assign position_o      = $signed(out_pos_q);

`ifndef SYNTHESIS
  // A result only enters the output register from the emit state.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit state");

  // The program never starts the divider while it is still busy.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The step counter stays inside the program.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (pc_q < PcW'(UcodeLen)))
    else $error("step counter beyond program");

  // A clipped drive sits at one of the limits.
  a_clip_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_q |-> (drv_q == $signed(16'h7FFF) || drv_q == $signed(16'h8000)))
    else $error("clip flag without a saturated drive");
`endif

endmodule

`default_nettype wire
